### rtl/core/pfc_pkg.sv
// pfc_pkg: shared types and constants of the playfair digraph cipher
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package pfc_pkg;

  localparam int unsigned GridN         = 5;
  localparam int unsigned LetterW       = 5;
  localparam int unsigned RowW          = GridN * LetterW;
  localparam int unsigned CfgIndexW     = 3;
  localparam int unsigned QueueDepthDef = 4;

  localparam logic [LetterW-1:0] LetterI = 5'd8;
  localparam logic [LetterW-1:0] LetterJ = 5'd9;
  localparam logic [LetterW-1:0] LetterQ = 5'd16;
  localparam logic [LetterW-1:0] LetterX = 5'd23;
  localparam logic [LetterW-1:0] LetterZ = 5'd25;

  // register indexes of the configuration port
  localparam logic [CfgIndexW-1:0] CfgGridRow0   = 3'd0;
  localparam logic [CfgIndexW-1:0] CfgGridRow1   = 3'd1;
  localparam logic [CfgIndexW-1:0] CfgGridRow2   = 3'd2;
  localparam logic [CfgIndexW-1:0] CfgGridRow3   = 3'd3;
  localparam logic [CfgIndexW-1:0] CfgGridRow4   = 3'd4;
  localparam logic [CfgIndexW-1:0] CfgDecryptMode = 3'd5;

  // reset grid: alphabet without J, row-major
  localparam logic [RowW-1:0] GridRow0Rst = 25'd4294688;
  localparam logic [RowW-1:0] GridRow1Rst = 25'd10755269;
  localparam logic [RowW-1:0] GridRow2Rst = 25'd16201099;
  localparam logic [RowW-1:0] GridRow3Rst = 25'd21613104;
  localparam logic [RowW-1:0] GridRow4Rst = 25'd27025109;

  typedef logic [GridN-1:0][RowW-1:0] grid_t;

  // one digraph waiting to be ciphered
  typedef struct packed {
    logic [LetterW-1:0] a;
    logic [LetterW-1:0] b;
    logic               last;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

endpackage

### rtl/core/playfair_digraph_cipher_top.sv
// playfair_digraph_cipher_top: grid registers and the front, queue and back
// depends on pfc_pkg, pfc_front, pfc_queue, pfc_back
`timescale 1ns / 1ps

// Streaming Playfair cipher. Letters enter one beat at a time; the front pairs
// them into digraphs (filler X, or Q after X, for a doubled letter, Z for a
// lone last letter) and pushes them into a QueueDepth-entry queue. The back
// pops one digraph, looks it up in the 5x5 grid combinationally and sends its
// two letters on two output beats. A letter is taken every cycle while the
// queue has room; a doubled letter with end_of_text stalls input until its
// second digraph is pushed. Sustained rate is set by the output port at one
// beat per cycle while out_stall_i is low: one input letter per cycle for
// ordinary text; each filler adds a beat. The user must write grid rows and
// decrypt_mode only while the block is idle; the block does not enforce it.
module playfair_digraph_cipher_top import pfc_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [LetterW-1:0]   letter_code_i,
  input  logic                 end_of_text_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [LetterW-1:0]   out_letter_o,
  output logic                 last_out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [RowW-1:0]      cfg_data_i
);

  grid_t grid_q;
  logic  decrypt_q;
  push_t push;
  logic  q_full, q_empty, q_pop;
  job_t  q_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q[0] <= GridRow0Rst;
      grid_q[1] <= GridRow1Rst;
      grid_q[2] <= GridRow2Rst;
      grid_q[3] <= GridRow3Rst;
      grid_q[4] <= GridRow4Rst;
      decrypt_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgGridRow0:    grid_q[0] <= cfg_data_i;
        CfgGridRow1:    grid_q[1] <= cfg_data_i;
        CfgGridRow2:    grid_q[2] <= cfg_data_i;
        CfgGridRow3:    grid_q[3] <= cfg_data_i;
        CfgGridRow4:    grid_q[4] <= cfg_data_i;
        CfgDecryptMode: decrypt_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  pfc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .letter_code_i (letter_code_i),
    .end_of_text_i (end_of_text_i),
    .in_stall_o    (in_stall_o),
    .q_full_i      (q_full),
    .push_o        (push)
  );

  pfc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  pfc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .grid_i       (grid_q),
    .decrypt_i    (decrypt_q),
    .q_empty_i    (q_empty),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_letter_o (out_letter_o),
    .last_out_o   (last_out_o)
  );

endmodule

### rtl/core/pfc_front.sv
// pfc_front: pairs incoming letters into digraphs and pushes them to the queue
// depends on pfc_pkg
`timescale 1ns / 1ps

module pfc_front import pfc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [LetterW-1:0] letter_code_i,
  input  logic               end_of_text_i,
  output logic               in_stall_o,
  input  logic               q_full_i,
  output push_t              push_o
);

  logic [LetterW-1:0] held_q, held_d;
  logic               held_valid_q, held_valid_d;
  logic               pend_q, pend_d;
  job_t               pend_job_q, pend_job_d;

  logic               accept;
  logic [LetterW-1:0] letter;
  logic [LetterW-1:0] filler;
  logic               first_valid;
  job_t               first_job;

  assign in_stall_o = pend_q | q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign letter     = (letter_code_i == LetterJ) ? LetterI : letter_code_i;
  assign filler     = (held_q == LetterX) ? LetterQ : LetterX;

  always_comb begin
    held_d       = held_q;
    held_valid_d = held_valid_q;
    pend_d       = pend_q;
    pend_job_d   = pend_job_q;
    first_valid  = 1'b0;
    first_job    = '{a: held_q, b: letter, last: end_of_text_i};
    if (pend_q && !q_full_i) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      if (held_valid_q) begin
        first_valid = 1'b1;
        if (letter == held_q) begin
          first_job = '{a: held_q, b: filler, last: 1'b0};
          if (end_of_text_i) begin
            // doubled letter at end of text gives a second digraph
            pend_d       = 1'b1;
            pend_job_d   = '{a: letter, b: LetterZ, last: 1'b1};
            held_valid_d = 1'b0;
          end else begin
            held_d = letter;
          end
        end else begin
          held_valid_d = 1'b0;
        end
      end else if (end_of_text_i) begin
        first_valid = 1'b1;
        first_job   = '{a: letter, b: LetterZ, last: 1'b1};
      end else begin
        held_d       = letter;
        held_valid_d = 1'b1;
      end
    end
  end

  always_comb begin
    if (pend_q) begin
      push_o = '{valid: ~q_full_i, job: pend_job_q};
    end else begin
      push_o = '{valid: first_valid, job: first_job};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= '0;
      held_valid_q <= 1'b0;
      pend_q       <= 1'b0;
    end else begin
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      pend_q       <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_job_q <= pend_job_d;
  end

endmodule

### rtl/core/pfc_queue.sv
// pfc_queue: small fifo of digraph jobs between front and back
// depends on pfc_pkg
`timescale 1ns / 1ps

module pfc_queue import pfc_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output job_t  head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i.valid & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

endmodule

### rtl/core/pfc_back.sv
// pfc_back: locates a digraph in the grid, applies the playfair rule and
// sends the two result letters one beat at a time; depends on pfc_pkg
`timescale 1ns / 1ps

module pfc_back import pfc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  grid_t              grid_i,
  input  logic               decrypt_i,
  input  logic               q_empty_i,
  input  job_t               q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [LetterW-1:0] out_letter_o,
  output logic               last_out_o
);

  // {row, col} of the first match in row-major order, origin when absent
  function automatic logic [5:0] locate(grid_t g, logic [LetterW-1:0] l);
    logic [5:0] pos;
    pos = '0;
    for (int r = GridN - 1; r >= 0; r--) begin
      for (int c = GridN - 1; c >= 0; c--) begin
        if (g[r][c*LetterW +: LetterW] == l) begin
          pos = {3'(r), 3'(c)};
        end
      end
    end
    return pos;
  endfunction

  function automatic logic [2:0] shift5(logic [2:0] v, logic dec);
    logic [2:0] res;
    if (dec) begin
      res = (v == 3'd0) ? 3'(GridN - 1) : v - 3'd1;
    end else begin
      res = (v == 3'(GridN - 1)) ? 3'd0 : v + 3'd1;
    end
    return res;
  endfunction

  logic [2:0]         ra, ca, rb, cb;
  logic [2:0]         ra_n, ca_n, rb_n, cb_n;
  logic [LetterW-1:0] l0, l1;
  logic               slot_free;

  logic               slot_valid_q, slot_valid_d;
  logic               slot_second_q, slot_second_d;
  logic [LetterW-1:0] l0_q, l1_q;
  logic               last_q;

  assign {ra, ca} = locate(grid_i, q_head_i.a);
  assign {rb, cb} = locate(grid_i, q_head_i.b);

  always_comb begin
    ra_n = ra;
    ca_n = ca;
    rb_n = rb;
    cb_n = cb;
    if (ca == cb) begin
      ra_n = shift5(ra, decrypt_i);
      rb_n = shift5(rb, decrypt_i);
    end else if (ra == rb) begin
      ca_n = shift5(ca, decrypt_i);
      cb_n = shift5(cb, decrypt_i);
    end else begin
      ca_n = cb;
      cb_n = ca;
    end
  end

  assign l0 = grid_i[ra_n][ca_n*LetterW +: LetterW];
  assign l1 = grid_i[rb_n][cb_n*LetterW +: LetterW];

  // slot frees once its second beat is taken
  assign slot_free = ~slot_valid_q | (slot_second_q & ~out_stall_i);
  assign q_pop_o   = slot_free & ~q_empty_i;

  always_comb begin
    slot_valid_d  = slot_valid_q;
    slot_second_d = slot_second_q;
    if (slot_valid_q && !out_stall_i) begin
      if (slot_second_q) begin
        slot_valid_d  = 1'b0;
        slot_second_d = 1'b0;
      end else begin
        slot_second_d = 1'b1;
      end
    end
    if (q_pop_o) begin
      slot_valid_d  = 1'b1;
      slot_second_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q  <= 1'b0;
      slot_second_q <= 1'b0;
    end else begin
      slot_valid_q  <= slot_valid_d;
      slot_second_q <= slot_second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      l0_q   <= l0;
      l1_q   <= l1;
      last_q <= q_head_i.last;
    end
  end

  assign out_valid_o  = slot_valid_q;
  assign out_letter_o = slot_second_q ? l1_q : l0_q;
  assign last_out_o   = slot_valid_q & slot_second_q & last_q;

endmodule

### rtl/core/pfc_checker.sv
// pfc_checker: port-level assertions on the cipher top, bound to it below
// depends on pfc_pkg
`timescale 1ns / 1ps

module pfc_checker import pfc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [LetterW-1:0] out_letter_o,
  input logic               last_out_o
);

  // stalled result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_letter_o))
    else $error("stalled output beat dropped or changed");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_out_o |-> out_valid_o)
    else $error("last_out shown without a valid beat");

  // results come in pairs, so a last beat is never followed by another last beat
  a_last_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_out_o |=> !last_out_o)
    else $error("two last beats back to back");

  // input stall only starts after an input beat was taken
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall raised without a preceding input beat");

endmodule

bind playfair_digraph_cipher_top pfc_checker u_pfc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_letter_o (out_letter_o),
  .last_out_o   (last_out_o)
);
